// ===== hw/rtl/at2t_pkg.sv =====
// shared constants and types for the atan2 turns pipeline
package at2t_pkg;

	// magnitude width: a 16-bit two's complement value can reach 32768
	localparam int MAG_W = 17;
	// fraction bits of the ratio and of the turn scale
	localparam int FRAC_BITS = 16;
	// one quotient bit per divider stage, z spans 0..65536
	localparam int DIV_STAGES = 17;
	// abs, sort, divider, two multiply stages, output register
	localparam int PIPE_DEPTH = DIV_STAGES + 5;

	// polynomial coefficients of the octant curve
	localparam logic [13:0] OCTANT_GAIN = 14'd8192;
	localparam logic [11:0] CURVE_COEF = 12'd2847;

	// reflection offsets in turn units
	localparam logic [15:0] QUARTER_TURN = 16'd16384;
	localparam logic [15:0] HALF_TURN = 16'd32768;

	// octant and quadrant flags that travel with each item
	typedef struct packed {
		logic steep;
		logic xneg;
		logic yneg;
		logic zero;
	} at2t_side_t;

endpackage

// ===== hw/rtl/at2t_if.sv =====
// stream channels for the vector input and the angle output

interface at2t_vec_if;
	logic valid;
	logic ready;
	logic signed [15:0] y_coord;
	logic signed [15:0] x_coord;

	modport source (output valid, output y_coord, output x_coord, input ready);
	modport sink (input valid, input y_coord, input x_coord, output ready);
endinterface

interface at2t_ang_if;
	logic valid;
	logic ready;
	logic [15:0] angle_turns;

	modport source (output valid, output angle_turns, input ready);
	modport sink (input valid, input angle_turns, output ready);
endinterface

// ===== hw/rtl/atan2_turns_approx_unit.sv =====
// top level: pipelined atan2 giving the vector angle in Q0.16 turns
//
// Takes one (y_coord, x_coord) item per cycle and returns its angle as a
// Q0.16 fraction of a full turn, (0,0) giving 0. In pipeline order:
// one stage forms magnitudes, one sorts them into min and max, seventeen
// stages of a restoring divider produce the ratio min/max one quotient bit
// each, two stages evaluate the octant polynomial (one multiplier each) and
// the last stage reflects into the octant and quadrant and holds the result.
// The whole pipeline advances together; vec.ready drops only while a result
// sits in the output register and ang.ready is low.
module atan2_turns_approx_unit (
	input logic clk,
	input logic arst_n,
	at2t_vec_if.sink vec,
	at2t_ang_if.source ang
);
	import at2t_pkg::*;

	logic adv;

	// stage 1: magnitudes
	logic vld_s1;
	logic [MAG_W-1:0] ax_s1, ay_s1;
	logic xneg_s1, yneg_s1;

	// divider stages, index 0 is the sort stage
	logic div_vld_s [0:DIV_STAGES];
	logic [MAG_W-1:0] div_rem_s [0:DIV_STAGES];
	logic [MAG_W-1:0] div_hi_s [0:DIV_STAGES];
	logic [DIV_STAGES-1:0] div_quo_s [0:DIV_STAGES];
	at2t_side_t div_side_s [0:DIV_STAGES];

	// polynomial stages
	logic vld_s20, vld_s21;
	logic [DIV_STAGES-1:0] z_s20;
	logic [28:0] crv_s20;
	logic [30:0] base_s21;
	at2t_side_t side_s20, side_s21;

	// reflection terms ahead of the output register
	logic [15:0] oct_ang;
	logic [15:0] hx_ang;

	// output register
	logic vld_s22;
	logic [15:0] angle_s22;

	// whole pipeline holds only while the output is stalled
	assign adv = !(vld_s22 && !ang.ready);
	assign vec.ready = adv;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vec.valid;
		end
	end

	// stage 1 data: two's complement magnitudes, -32768 gives 32768
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= vec.x_coord[15] ? MAG_W'(17'h10000 - {1'b0, vec.x_coord})
				: {1'b0, vec.x_coord};
			ay_s1 <= vec.y_coord[15] ? MAG_W'(17'h10000 - {1'b0, vec.y_coord})
				: {1'b0, vec.y_coord};
			xneg_s1 <= vec.x_coord[15];
			yneg_s1 <= vec.y_coord[15];
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (adv) begin
			div_vld_s[0] <= vld_s1;
		end
	end

	// stage 2 data: sort into max and min, min is the first remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			div_hi_s[0] <= (ax_s1 < ay_s1) ? ay_s1 : ax_s1;
			div_rem_s[0] <= (ax_s1 < ay_s1) ? ax_s1 : ay_s1;
			div_quo_s[0] <= '0;
			div_side_s[0].steep <= (ax_s1 < ay_s1);
			div_side_s[0].xneg <= xneg_s1;
			div_side_s[0].yneg <= yneg_s1;
			div_side_s[0].zero <= (ax_s1 == '0) && (ay_s1 == '0);
		end
	end

	// restoring divider, one quotient bit per stage, msb first
	// remainder stays below the divisor, so the shift never overflows
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [MAG_W-1:0] trial;
		logic fits;

		assign trial = (k == 0) ? div_rem_s[k] : {div_rem_s[k][MAG_W-2:0], 1'b0};
		assign fits = (trial >= div_hi_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				div_vld_s[k+1] <= div_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[k+1] <= fits ? MAG_W'(trial - div_hi_s[k]) : trial;
				div_hi_s[k+1] <= div_hi_s[k];
				div_quo_s[k+1] <= {div_quo_s[k][DIV_STAGES-2:0], fits};
				div_side_s[k+1] <= div_side_s[k];
			end
		end
	end

	// polynomial and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s20 <= 1'b0;
			vld_s21 <= 1'b0;
			vld_s22 <= 1'b0;
		end else if (adv) begin
			vld_s20 <= div_vld_s[DIV_STAGES];
			vld_s21 <= vld_s20;
			vld_s22 <= vld_s21;
		end
	end

	// curve term 2847 * (1 - z)
	always_ff @(posedge clk) begin
		if (adv) begin
			crv_s20 <= CURVE_COEF * MAG_W'(17'h10000 - div_quo_s[DIV_STAGES]);
			z_s20 <= div_quo_s[DIV_STAGES];
			side_s20 <= div_side_s[DIV_STAGES];
		end
	end

	// octant angle z * (8192 + curve term)
	always_ff @(posedge clk) begin
		if (adv) begin
			base_s21 <= z_s20 * 14'(OCTANT_GAIN + 14'(crv_s20[28:FRAC_BITS]));
			side_s21 <= side_s20;
		end
	end

	// octant and half-turn reflection
	assign oct_ang = side_s21.steep ? 16'(QUARTER_TURN - {1'b0, base_s21[30:FRAC_BITS]})
		: {1'b0, base_s21[30:FRAC_BITS]};
	assign hx_ang = side_s21.xneg ? 16'(HALF_TURN - oct_ang) : oct_ang;

	// quadrant reflection, modulo one turn
	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s21.zero) begin
				angle_s22 <= '0;
			end else begin
				angle_s22 <= side_s21.yneg ? 16'(16'd0 - hx_ang) : hx_ang;
			end
		end
	end

	assign ang.valid = vld_s22;
	assign ang.angle_turns = angle_s22;

endmodule

// ===== hw/rtl/at2t_chk.sv =====
// port checker for the atan2 turns pipeline, bound to the top level
module at2t_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [15:0] angle_turns
);
	import at2t_pkg::*;

	logic [5:0] inflight_q;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= 6'(inflight_q + 6'(in_valid && in_ready)
				- 6'(out_valid && out_ready));
		end
	end

	// input back-pressure only comes from a stalled result
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a stalled result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(angle_turns)))
		else $error("stalled result changed or dropped");

	// no result without an accepted item behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inflight_q != 6'd0))
		else $error("result without an accepted item");

	// never more items in flight than pipeline stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 6'(PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

endmodule

bind atan2_turns_approx_unit at2t_chk u_at2t_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(vec.valid),
	.in_ready(vec.ready),
	.out_valid(ang.valid),
	.out_ready(ang.ready),
	.angle_turns(ang.angle_turns)
);
